[rtl/core/tes_pkg.sv]
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and constants for the text encoding sniffer.
// ----------------------------------------------------------------------------
package tes_pkg;

    // Sample sizes
    localparam int unsigned PAIR_SAMPLE_BYTES   = 4096;
    localparam int unsigned BINARY_SAMPLE_BYTES = 8192;

    // Byte-position counter saturates at the larger sample (never below 4)
    localparam int unsigned SEEN_CAP_RAW = (PAIR_SAMPLE_BYTES > BINARY_SAMPLE_BYTES)
                                           ? PAIR_SAMPLE_BYTES : BINARY_SAMPLE_BYTES;
    localparam int unsigned SEEN_CAP     = (SEEN_CAP_RAW < 4) ? 4 : SEEN_CAP_RAW;
    localparam int unsigned SEEN_W       = $clog2(SEEN_CAP + 1);

    // Pair sample: complete pairs only
    localparam int unsigned PAIR_LIMIT   = PAIR_SAMPLE_BYTES & ~32'd1;
    localparam int unsigned PAIR_CNT_MAX = PAIR_LIMIT / 2;
    localparam int unsigned PAIR_CNT_W   = $clog2(PAIR_CNT_MAX + 1);
    localparam int unsigned PAIRS_W      = $clog2(PAIR_SAMPLE_BYTES / 2 + 1);

    // Binary sample
    localparam int unsigned CTRL_W       = $clog2(BINARY_SAMPLE_BYTES + 1);

    // Heuristic factors
    localparam int unsigned THR_DIV      = 3;
    localparam int unsigned THR_MIN      = 2;
    localparam int unsigned MINOR_DIV    = 10;
    localparam int unsigned CTRL_FACTOR  = 20;

    // Byte codes
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_FF    = 8'h0C;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // Byte-order marks
    localparam logic [23:0] MARK_UTF8    = 24'hEFBBBF;
    localparam logic [15:0] MARK_UTF16LE = 16'hFFFE;
    localparam logic [15:0] MARK_UTF16BE = 16'hFEFF;

    typedef enum logic [1:0] {
        BOM_NONE    = 2'd0,
        BOM_UTF8    = 2'd1,
        BOM_UTF16LE = 2'd2,
        BOM_UTF16BE = 2'd3
    } bom_kind_t;

    typedef enum logic [1:0] {
        GUESS_NONE = 2'd0,
        GUESS_LE   = 2'd1,
        GUESS_BE   = 2'd2
    } utf16_guess_t;

endpackage

[rtl/core/text_encoding_sniffer_unit.sv]
// ----------------------------------------------------------------------------
// text_encoding_sniffer_unit
// Byte-stream sniffer: byte-order mark, UTF-16 order guess, binary check.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_*): one file byte per request, s_last_byte set on the
//   final byte. Every file has at least one byte.
//   Result channel (m_*): exactly one request per file, raised after the
//   final byte, carrying bom_kind, utf16_guess and is_binary.
//   The result for a final byte is registered in the result register.
//   Throughput: one byte per cycle while no final byte waits on the result
//   register, set by the input register feeding the counter update in a single pass.
//   Reset (aresetn low, synchronous): all counters clear, both channels empty.
//   Counters also clear after each final byte, so files follow back to back.
//   Stall: while a result waits on m_ready, ordinary bytes keep flowing; a
//   following final byte is held in the input register until the result
//   register is free, and s_ready stays low while that final byte is held.
// ----------------------------------------------------------------------------
module text_encoding_sniffer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_bom_kind,
    output logic [1:0] m_utf16_guess,
    output logic       m_is_binary
);
    import tes_pkg::*;

    // Input register
    logic                  in_vld_reg, in_vld_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;

    // Running file state
    logic [SEEN_W-1:0]     seen_reg, seen_next;
    logic                  odd_reg, odd_next;
    logic [23:0]           lead_reg, lead_next;
    logic [PAIR_CNT_W-1:0] even_zero_reg, even_zero_next;
    logic [PAIR_CNT_W-1:0] odd_zero_reg, odd_zero_next;
    logic [CTRL_W-1:0]     ctrl_reg, ctrl_next;
    logic                  nul_reg, nul_next;

    // Result register
    logic                  out_vld_reg, out_vld_next;
    bom_kind_t             bom_reg, bom_next;
    utf16_guess_t          guess_reg, guess_next;
    logic                  bin_reg, bin_next;

    // Updated state for the byte in the input register
    logic [SEEN_W-1:0]     upd_seen;
    logic                  upd_odd;
    logic [23:0]           upd_lead;
    logic [PAIR_CNT_W-1:0] upd_even_zero, upd_odd_zero;
    logic [CTRL_W-1:0]     upd_ctrl;
    logic                  upd_nul;

    logic                  advance;
    logic                  is_zero, is_ctrl;
    logic [PAIRS_W-1:0]    pairs;
    logic [CTRL_W-1:0]     sample;
    logic                  le_hit, be_hit;

    // A byte leaves the input register unless it is a final byte and the
    // result register is still occupied.
    assign advance = in_vld_reg && (!in_last_reg || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    assign is_zero = (in_byte_reg == BYTE_NUL);
    assign is_ctrl = (in_byte_reg < BYTE_SPACE) && !is_zero
                     && (in_byte_reg != BYTE_TAB) && (in_byte_reg != BYTE_LF)
                     && (in_byte_reg != BYTE_FF)  && (in_byte_reg != BYTE_CR);

    // State update for one byte
    always_comb begin
        upd_lead      = lead_reg;
        upd_even_zero = even_zero_reg;
        upd_odd_zero  = odd_zero_reg;
        upd_ctrl      = ctrl_reg;
        upd_nul       = nul_reg;

        // First three bytes, byte 0 in the top octet
        if (seen_reg < SEEN_W'(3)) begin
            unique case (seen_reg[1:0])
                2'd0:    upd_lead[23:16] = in_byte_reg;
                2'd1:    upd_lead[15:8]  = in_byte_reg;
                default: upd_lead[7:0]   = in_byte_reg;
            endcase
        end

        // Zero bytes by position parity, within complete pairs
        if (seen_reg < SEEN_W'(PAIR_LIMIT) && is_zero) begin
            if (!seen_reg[0]) begin
                upd_even_zero = even_zero_reg + PAIR_CNT_W'(1);
            end else begin
                upd_odd_zero  = odd_zero_reg + PAIR_CNT_W'(1);
            end
        end

        // NUL and control characters within the binary sample
        if (seen_reg < SEEN_W'(BINARY_SAMPLE_BYTES)) begin
            if (is_zero) begin
                upd_nul = 1'b1;
            end else if (is_ctrl) begin
                upd_ctrl = ctrl_reg + CTRL_W'(1);
            end
        end

        upd_seen = (seen_reg < SEEN_W'(SEEN_CAP)) ? seen_reg + SEEN_W'(1) : seen_reg;
        upd_odd  = !odd_reg;
    end

    // Decision on the final byte, from the updated state
    always_comb begin
        bom_next   = BOM_NONE;
        guess_next = GUESS_NONE;
        bin_next   = 1'b0;

        pairs  = (upd_seen < SEEN_W'(PAIR_SAMPLE_BYTES))
                 ? PAIRS_W'(upd_seen >> 1) : PAIRS_W'(PAIR_SAMPLE_BYTES / 2);
        sample = (upd_seen < SEEN_W'(BINARY_SAMPLE_BYTES))
                 ? CTRL_W'(upd_seen) : CTRL_W'(BINARY_SAMPLE_BYTES);

        // count >= max(2, pairs/3)    <=>  count >= 2 and pairs <= 3*count + 2
        // other  < pairs/10           <=>  10*(other + 1) <= pairs
        le_hit = (upd_odd_zero >= PAIR_CNT_W'(THR_MIN))
                 && ((PAIRS_W + 3)'(pairs)
                     <= (PAIRS_W + 3)'(upd_odd_zero) * (PAIRS_W + 3)'(THR_DIV)
                        + (PAIRS_W + 3)'(THR_DIV - 1))
                 && ((PAIR_CNT_W + 5)'(upd_even_zero + PAIR_CNT_W'(0)) + (PAIR_CNT_W + 5)'(1))
                    * (PAIR_CNT_W + 5)'(MINOR_DIV) <= (PAIR_CNT_W + 5)'(pairs);
        be_hit = (upd_even_zero >= PAIR_CNT_W'(THR_MIN))
                 && ((PAIRS_W + 3)'(pairs)
                     <= (PAIRS_W + 3)'(upd_even_zero) * (PAIRS_W + 3)'(THR_DIV)
                        + (PAIRS_W + 3)'(THR_DIV - 1))
                 && ((PAIR_CNT_W + 5)'(upd_odd_zero) + (PAIR_CNT_W + 5)'(1))
                    * (PAIR_CNT_W + 5)'(MINOR_DIV) <= (PAIR_CNT_W + 5)'(pairs);

        // Marks count only when the file holds all of their bytes
        priority if (upd_seen >= SEEN_W'(3) && upd_lead == MARK_UTF8) begin
            bom_next = BOM_UTF8;
        end else if (upd_seen >= SEEN_W'(2) && upd_lead[23:8] == MARK_UTF16LE) begin
            bom_next = BOM_UTF16LE;
        end else if (upd_seen >= SEEN_W'(2) && upd_lead[23:8] == MARK_UTF16BE) begin
            bom_next = BOM_UTF16BE;
        end else begin
            bom_next = BOM_NONE;
        end

        // Order guess: no mark, even length of at least four
        if (bom_next == BOM_NONE && upd_seen >= SEEN_W'(4) && !upd_odd) begin
            priority if (le_hit) begin
                guess_next = GUESS_LE;
            end else if (be_hit) begin
                guess_next = GUESS_BE;
            end else begin
                guess_next = GUESS_NONE;
            end
        end

        if (bom_next != BOM_UTF16LE && bom_next != BOM_UTF16BE
            && guess_next == GUESS_NONE) begin
            bin_next = upd_nul
                       || ((CTRL_W + 5)'(upd_ctrl) * (CTRL_W + 5)'(CTRL_FACTOR)
                           > (CTRL_W + 5)'(sample));
        end
    end

    // Next values for the registers
    always_comb begin
        in_vld_next    = in_vld_reg;
        seen_next      = seen_reg;
        odd_next       = odd_reg;
        lead_next      = lead_reg;
        even_zero_next = even_zero_reg;
        odd_zero_next  = odd_zero_reg;
        ctrl_next      = ctrl_reg;
        nul_next       = nul_reg;
        out_vld_next   = out_vld_reg && !m_ready;

        if (s_ready) begin
            in_vld_next = s_valid;
        end

        if (advance) begin
            if (in_last_reg) begin
                // file done: clear for the next one
                seen_next      = '0;
                odd_next       = 1'b0;
                lead_next      = '0;
                even_zero_next = '0;
                odd_zero_next  = '0;
                ctrl_next      = '0;
                nul_next       = 1'b0;
                out_vld_next   = 1'b1;
            end else begin
                seen_next      = upd_seen;
                odd_next       = upd_odd;
                lead_next      = upd_lead;
                even_zero_next = upd_even_zero;
                odd_zero_next  = upd_odd_zero;
                ctrl_next      = upd_ctrl;
                nul_next       = upd_nul;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            seen_reg      <= '0;
            odd_reg       <= 1'b0;
            lead_reg      <= '0;
            even_zero_reg <= '0;
            odd_zero_reg  <= '0;
            ctrl_reg      <= '0;
            nul_reg       <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            in_vld_reg    <= in_vld_next;
            seen_reg      <= seen_next;
            odd_reg       <= odd_next;
            lead_reg      <= lead_next;
            even_zero_reg <= even_zero_next;
            odd_zero_reg  <= odd_zero_next;
            ctrl_reg      <= ctrl_next;
            nul_reg       <= nul_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_byte_value;
            in_last_reg <= s_last_byte;
        end
        if (advance && in_last_reg) begin
            bom_reg   <= bom_next;
            guess_reg <= guess_next;
            bin_reg   <= bin_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_bom_kind    = bom_reg;
    assign m_utf16_guess = guess_reg;
    assign m_is_binary   = bin_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A result appears only after a final byte has been processed
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && m_valid && !$past(m_valid)) |-> $past(advance && in_last_reg))
        else $error("result raised without a final byte");

    // A mark excludes an order guess
    a_mark_no_guess: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (bom_reg == BOM_NONE || guess_reg == GUESS_NONE))
        else $error("order guess given alongside a mark");

    // UTF-16 by mark or by guess is never called binary
    a_utf16_not_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (bom_reg == BOM_UTF16LE || bom_reg == BOM_UTF16BE
                     || guess_reg != GUESS_NONE)) |-> !bin_reg)
        else $error("UTF-16 content flagged binary");

    // File state is clear after a final byte
    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(advance && in_last_reg))
        |-> (seen_reg == '0 && !nul_reg && ctrl_reg == '0))
        else $error("file state not cleared after final byte");

endmodule
